// ===== rtl/fafc_pkg.sv =====
// shared types and constants for the fifo-replacement tag directory
package fafc_pkg;

    localparam int WAYS     = 16;
    localparam int IDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W    = $clog2(WAYS + 1);
    localparam int ADDR_W   = 64;
    localparam int TAG_W    = 64;
    localparam int SHIFT_W  = 6;
    localparam int CTR_W    = 32;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(4);

    // occupancy flags of the request queue
    typedef struct packed {
        logic empty;
        logic full;
    } fafc_q_status_t;

    // sequencer states of the lookup engine
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } fafc_state_t;

endpackage

// ===== rtl/fafc_front.sv =====
// front end: shift register, request handshake and tag extraction
module fafc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fafc_pkg::SHIFT_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fafc_pkg::ADDR_W-1:0]   address,
    input  fafc_pkg::fafc_q_status_t      q_status,
    output logic                          push,
    output logic [fafc_pkg::TAG_W-1:0]    push_tag
);
    import fafc_pkg::*;

    logic [SHIFT_W-1:0] shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            shift_reg <= cfg_data;
        end
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !in_stall;
    // tag is the address with its low shift_reg bits (the block offset) dropped
    assign push_tag = TAG_W'(address >> shift_reg);

endmodule

// ===== rtl/fafc_queue.sv =====
// two-entry tag queue between front end and lookup engine
module fafc_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [fafc_pkg::TAG_W-1:0]  push_tag,
    input  logic                        pop,
    output logic [fafc_pkg::TAG_W-1:0]  pop_tag,
    output fafc_pkg::fafc_q_status_t    status
);
    import fafc_pkg::*;

    logic [TAG_W-1:0]  entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign pop_tag      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tag;
        end
    end

endmodule

// ===== rtl/fafc_back.sv =====
// lookup engine: serial tag scan, fifo replacement, counters, result register
module fafc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fafc_pkg::fafc_q_status_t    q_status,
    input  logic [fafc_pkg::TAG_W-1:0]  q_tag,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        hit,
    output logic                        evicted,
    output logic [fafc_pkg::CTR_W-1:0]  hits_total,
    output logic [fafc_pkg::CTR_W-1:0]  misses_total,
    output logic [fafc_pkg::CTR_W-1:0]  evictions_total
);
    import fafc_pkg::*;

    logic [TAG_W-1:0] tag_mem [WAYS];
    logic [TAG_W-1:0] rd_data_reg;

    fafc_state_t      state_reg, state_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] oldest_reg, oldest_next;
    logic [CTR_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [CTR_W-1:0] miss_cnt_reg, miss_cnt_next;
    logic [CTR_W-1:0] evict_cnt_reg, evict_cnt_next;
    logic             res_hit_reg, res_hit_next;
    logic             res_evict_reg, res_evict_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;

    logic             match;
    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    assign match = cmp_valid_reg && (rd_data_reg == tag_reg);
    assign full  = (fill_reg == CNT_W'(WAYS));
    assign wr_addr = full ? oldest_reg : fill_reg[IDX_W-1:0];
    assign wr_en = (state_reg == S_SCAN) && !match && (idx_reg == fill_reg);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign pop = (state_reg == S_IDLE) && !q_status.empty;

    always_comb
    begin
        state_next     = state_reg;
        tag_next       = tag_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        res_hit_next   = res_hit_reg;
        res_evict_next = res_evict_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    tag_next   = q_tag;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (match)
                begin
                    res_hit_next   = 1'b1;
                    res_evict_next = 1'b0;
                    hit_cnt_next   = hit_cnt_reg + 1'b1;
                    state_next     = S_DONE;
                end
                else if (idx_reg == fill_reg)
                begin
                    // every valid way compared without a match
                    res_hit_next  = 1'b0;
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                    if (full)
                    begin
                        res_evict_next = 1'b1;
                        evict_cnt_next = evict_cnt_reg + 1'b1;
                        oldest_next    = (oldest_reg == IDX_W'(WAYS - 1)) ? '0
                                         : IDX_W'(oldest_reg + 1'b1);
                    end
                    else
                    begin
                        res_evict_next = 1'b0;
                        fill_next      = CNT_W'(fill_reg + 1'b1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next       = CNT_W'(idx_reg + 1'b1);
                    cmp_valid_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg       <= tag_next;
        res_hit_reg   <= res_hit_next;
        res_evict_reg <= res_evict_next;
        if (out_load)
        begin
            hit             <= res_hit_reg;
            evicted         <= res_evict_reg;
            hits_total      <= hit_cnt_reg;
            misses_total    <= miss_cnt_reg;
            evictions_total <= evict_cnt_reg;
        end
    end

    // tag store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr] <= tag_reg;
        end
        rd_data_reg <= tag_mem[idx_reg[IDX_W-1:0]];
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/fully_associative_fifo_cache_tags_top.sv =====
// top level of the fully associative tag directory with fifo replacement
// lookup: a request accepted into the queue is scanned way by way; on a miss all f valid
//   ways are compared, on a hit in way k the scan stops there; f is at most 16
// flow: one request in the lookup engine at a time, up to two more wait in the queue; set by
//   the way-by-way scan through one read port; a stalled result holds the next request back
// reset: rst_n async, active low; clears control state and counters, shift back to 4
module fully_associative_fifo_cache_tags_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write: address_shift
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fafc_pkg::SHIFT_W-1:0]  cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fafc_pkg::ADDR_W-1:0]   address,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic                          evicted,
    output logic [fafc_pkg::CTR_W-1:0]    hits_total,
    output logic [fafc_pkg::CTR_W-1:0]    misses_total,
    output logic [fafc_pkg::CTR_W-1:0]    evictions_total
);
    import fafc_pkg::*;

    // front to queue
    logic             push;
    logic [TAG_W-1:0] push_tag;
    // queue to lookup engine
    logic             pop;
    logic [TAG_W-1:0] pop_tag;
    fafc_q_status_t   q_status;

    // front end takes requests while the queue has room and forms the tag
    fafc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .address  (address),
        .q_status (q_status),
        .push     (push),
        .push_tag (push_tag)
    );

    // short queue decouples the request side from the serial lookup
    fafc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_tag(push_tag),
        .pop     (pop),
        .pop_tag (pop_tag),
        .status  (q_status)
    );

    // lookup engine scans the valid ways, replaces in fifo order, keeps counters
    // and holds the finished result in an output register
    fafc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .q_tag          (pop_tag),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .evicted        (evicted),
        .hits_total     (hits_total),
        .misses_total   (misses_total),
        .evictions_total(evictions_total)
    );

endmodule
